/* design/cnns_pkg.sv */
// Shared types, sizes and codes for the cosine nearest neighbor search block.
package cnns_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int MAX_DIM     = 64;

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int POS_W  = $clog2(MAX_DIM + 2);
	localparam int ADDR_W = IDX_W + DIM_W;

	// A norm is a sum of up to MAX_DIM squares of at most 2^30 each.
	localparam int MAG_W  = 31 + $clog2(MAX_DIM);
	localparam int DOT_W  = MAG_W + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int REM_W  = PROD_W + 1;
	localparam int QUO_W  = 31;
	localparam int RAD_W  = 32;
	localparam int SQRT_N = (QUO_W + 1) / 2;
	localparam int STEP_W = $clog2(MAG_W);
	localparam int SCORE_W = 17;

	localparam logic signed [SCORE_W-1:0] SCORE_MIN  = SCORE_W'(-32768);
	localparam logic signed [SCORE_W-1:0] SCORE_CLIP = SCORE_W'(32767);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_BADLEN  = 3'd1,
		ST_FULL    = 3'd2,
		ST_FOUND   = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ACC_DOT = 2'd0,
		ACC_N1  = 2'd1,
		ACC_N2  = 2'd2
	} acc_sel_t;

	typedef struct packed {
		logic     clr;
		logic     valid;
		acc_sel_t dst;
	} mac_ctrl_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] element_value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         best_entry;
		logic signed [15:0] score;
		logic [6:0]         entry_count;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEN,
		S_CHK,
		S_RD,
		S_M0,
		S_M1,
		S_M2,
		S_FLUSH,
		S_CSTART,
		S_COSW,
		S_DONE
	} top_state_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_MULD,
		C_MULP,
		C_DIV,
		C_SQRT,
		C_DONE
	} cos_state_t;

endpackage

/* design/cnns_mac.sv */
// Shared multiplier with a registered product and the dot and norm accumulators.
module cnns_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cnns_pkg::mac_ctrl_t              ctrl,
	input  logic signed [15:0]               a,
	input  logic signed [15:0]               b,
	output logic signed [cnns_pkg::DOT_W-1:0] dot,
	output logic [cnns_pkg::MAG_W-1:0]       n1,
	output logic [cnns_pkg::MAG_W-1:0]       n2
);
	import cnns_pkg::*;

	logic signed [31:0]       prod_s1;
	logic                     valid_s1;
	acc_sel_t                 dst_s1;
	logic signed [DOT_W-1:0]  dot_q;
	logic [MAG_W-1:0]         n1_q;
	logic [MAG_W-1:0]         n2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 32'(a * b);
		dst_s1  <= ctrl.dst;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			dot_q <= '0;
			n1_q  <= '0;
			n2_q  <= '0;
		end else if (valid_s1) begin
			case (dst_s1)
				ACC_DOT: dot_q <= dot_q + DOT_W'(prod_s1);
				ACC_N1:  n1_q  <= n1_q + MAG_W'($unsigned(prod_s1));
				ACC_N2:  n2_q  <= n2_q + MAG_W'($unsigned(prod_s1));
				default: dot_q <= dot_q;
			endcase
		end
	end

	assign dot = dot_q;
	assign n1  = n1_q;
	assign n2  = n2_q;

endmodule

/* design/cnns_cos.sv */
// Iterative cosine score unit: serial multiplies, restoring division and bitwise square root.
module cnns_cos (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [cnns_pkg::DOT_W-1:0]   dot,
	input  logic [cnns_pkg::MAG_W-1:0]          n1,
	input  logic [cnns_pkg::MAG_W-1:0]          n2,
	output logic                                done,
	output logic signed [cnns_pkg::SCORE_W-1:0] score
);
	import cnns_pkg::*;

	cos_state_t state_q, state_d;

	logic [PROD_W-1:0] mcand_q;
	logic [MAG_W-1:0]  mplier_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] d_q;
	logic [PROD_W-1:0] p_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [RAD_W-1:0]  op_q;
	logic [RAD_W-1:0]  res_q;
	logic [RAD_W-1:0]  one_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;

	logic signed [DOT_W-1:0] dot_abs;
	logic [PROD_W-1:0]       acc_nx;
	logic                    rem_ge;
	logic [REM_W-1:0]        rem_nx;
	logic [QUO_W-1:0]        quo_nx;
	logic [RAD_W-1:0]        trial;
	logic                    mul_end;
	logic                    div_end;
	logic                    sqrt_end;
	logic                    zero_norm;

	always_comb begin
		dot_abs   = (dot < 0) ? -dot : dot;
		acc_nx    = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
		rem_ge    = rem_q >= {1'b0, p_q};
		rem_nx    = rem_ge ? (rem_q - {1'b0, p_q}) : rem_q;
		quo_nx    = {quo_q[QUO_W-2:0], rem_ge};
		trial     = res_q + one_q;
		mul_end   = step_q == STEP_W'(MAG_W - 1);
		div_end   = step_q == STEP_W'(QUO_W - 1);
		sqrt_end  = step_q == STEP_W'(SQRT_N - 1);
		zero_norm = (n1 == '0) || (n2 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			C_IDLE: begin
				if (start) begin
					state_d = zero_norm ? C_DONE : C_MULD;
				end
			end
			C_MULD: begin
				if (mul_end) begin
					state_d = C_MULP;
				end
			end
			C_MULP: begin
				if (mul_end) begin
					state_d = C_DIV;
				end
			end
			C_DIV: begin
				if (div_end) begin
					state_d = C_SQRT;
				end
			end
			C_SQRT: begin
				if (sqrt_end) begin
					state_d = C_DONE;
				end
			end
			C_DONE: begin
				done    = 1'b1;
				state_d = C_IDLE;
			end
			default: state_d = C_IDLE;
		endcase
	end

	// The norms and the dot product are held steady by the caller until done.
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				neg_q    <= dot < 0;
				mcand_q  <= PROD_W'(dot_abs[MAG_W-1:0]);
				mplier_q <= dot_abs[MAG_W-1:0];
				acc_q    <= '0;
				step_q   <= '0;
				res_q    <= '0;
			end
			C_MULD: begin
				acc_q    <= acc_nx;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				step_q   <= step_q + STEP_W'(1);
				if (mul_end) begin
					d_q      <= acc_nx;
					acc_q    <= '0;
					mcand_q  <= PROD_W'(n1);
					mplier_q <= n2;
					step_q   <= '0;
				end
			end
			C_MULP: begin
				acc_q    <= acc_nx;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				step_q   <= step_q + STEP_W'(1);
				if (mul_end) begin
					p_q    <= acc_nx;
					rem_q  <= REM_W'(d_q);
					quo_q  <= '0;
					step_q <= '0;
				end
			end
			C_DIV: begin
				rem_q  <= rem_nx << 1;
				quo_q  <= quo_nx;
				step_q <= step_q + STEP_W'(1);
				if (div_end) begin
					op_q   <= RAD_W'(quo_nx);
					res_q  <= '0;
					one_q  <= RAD_W'(1) << (QUO_W - 1);
					step_q <= '0;
				end
			end
			C_SQRT: begin
				if (op_q >= trial) begin
					op_q  <= op_q - trial;
					res_q <= (res_q >> 1) + one_q;
				end else begin
					res_q <= res_q >> 1;
				end
				one_q  <= one_q >> 2;
				step_q <= step_q + STEP_W'(1);
			end
			default: step_q <= step_q;
		endcase
	end

	assign score = neg_q ? -$signed(SCORE_W'(res_q)) : $signed(SCORE_W'(res_q));

endmodule

/* design/cosine_nearest_neighbor_search_top.sv */
// Top level: entry store, query buffer, scan sequencer and result register.
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   item (op, element_value, last)
//  result    out        result_valid / result_stall  result (status, best_entry,
//                                                 score, entry_count)
//  config    in         cfg_wr_en                 cfg_wr_data (vector_length)
//
// Add, clear and plain query elements are taken while item_stall is low. A clear, an add's
// last element, or a query's last element that starts no scan gives a result the next cycle.
// Any other query's last element starts a scan: an entry of another length scores zero,
// and an entry of the query's length runs through the one shared 16x16 multiplier and the
// bit-serial multiply, divide and root steps of the score unit; then the result loads.
// Reset clears the counters and the sequencer; the stores need no clearing pass.
// While a scan runs, or a result is held by result_stall, item_stall stays high.
module cosine_nearest_neighbor_search_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  cnns_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output cnns_pkg::result_t result,
	input  logic              cfg_wr_en,
	input  logic [6:0]        cfg_wr_data
);
	import cnns_pkg::*;

	logic signed [15:0] store_mem [MAX_ENTRIES*MAX_DIM];
	logic [POS_W-1:0]   len_mem [MAX_ENTRIES];
	logic signed [15:0] qbuf_mem [MAX_DIM];

	top_state_t state_q, state_d;

	logic [6:0]       vlen_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] fill_q;
	logic [POS_W-1:0] qpos_q;
	logic [POS_W-1:0] qlen_q;
	logic [IDX_W-1:0] ent_q;
	logic [DIM_W-1:0] elem_q;
	logic signed [SCORE_W-1:0] best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             res_valid_q;
	result_t          res_q;

	logic signed [15:0] e_rd_q;
	logic signed [15:0] q_rd_q;
	logic [POS_W-1:0]   len_rd_q;

	logic             in_take;
	logic             out_free;
	logic [POS_W-1:0] fill_nx;
	logic [POS_W-1:0] qpos_nx;
	logic             add_bad;
	logic             add_full;
	logic             add_ok;
	logic             query_go;
	logic             ent_last;
	logic             elem_last;
	logic             cand_valid;
	logic signed [SCORE_W-1:0] cand_score;
	logic             res_load;
	result_t          res_next;

	mac_ctrl_t          mac_ctrl;
	logic signed [15:0] mac_a;
	logic signed [15:0] mac_b;
	logic signed [DOT_W-1:0] acc_dot;
	logic [MAG_W-1:0]   acc_n1;
	logic [MAG_W-1:0]   acc_n2;
	logic               cos_start;
	logic               cos_done;
	logic signed [SCORE_W-1:0] cos_score;

	cnns_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (mac_a),
		.b      (mac_b),
		.dot    (acc_dot),
		.n1     (acc_n1),
		.n2     (acc_n2)
	);

	cnns_cos u_cos (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cos_start),
		.dot    (acc_dot),
		.n1     (acc_n1),
		.n2     (acc_n2),
		.done   (cos_done),
		.score  (cos_score)
	);

	always_comb begin
		out_free   = !res_valid_q || !result_stall;
		item_stall = (state_q != S_IDLE) || !out_free;
		in_take    = item_valid && !item_stall;
		fill_nx    = (32'(fill_q) <= MAX_DIM) ? fill_q + POS_W'(1) : fill_q;
		qpos_nx    = (32'(qpos_q) <= MAX_DIM) ? qpos_q + POS_W'(1) : qpos_q;
		add_bad    = (vlen_q == '0) || (32'(vlen_q) > MAX_DIM)
			|| (32'(fill_nx) != 32'(vlen_q));
		add_full   = 32'(cnt_q) >= MAX_ENTRIES;
		add_ok     = in_take && (item.op == OP_ADD) && item.last && !add_bad && !add_full;
		query_go   = in_take && (item.op == OP_QUERY) && item.last
			&& (vlen_q != '0) && (cnt_q != '0);
		ent_last   = (CNT_W'(ent_q) + CNT_W'(1)) == cnt_q;
		elem_last  = (POS_W'(elem_q) + POS_W'(1)) == qlen_q;
		cand_valid = ((state_q == S_CHK) && (len_rd_q != qlen_q))
			|| ((state_q == S_COSW) && cos_done);
		cand_score = (state_q == S_COSW) ? cos_score : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mac_ctrl     = '{clr: 1'b0, valid: 1'b0, dst: ACC_DOT};
		mac_a        = q_rd_q;
		mac_b        = e_rd_q;
		cos_start    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (query_go) begin
					state_d = S_LEN;
				end
			end
			S_LEN: state_d = S_CHK;
			S_CHK: begin
				if (len_rd_q == qlen_q) begin
					mac_ctrl.clr = 1'b1;
					state_d      = S_RD;
				end else begin
					state_d = ent_last ? S_DONE : S_LEN;
				end
			end
			S_RD: state_d = S_M0;
			S_M0: begin
				mac_ctrl.valid = 1'b1;
				mac_ctrl.dst   = ACC_DOT;
				state_d        = S_M1;
			end
			S_M1: begin
				mac_ctrl.valid = 1'b1;
				mac_ctrl.dst   = ACC_N1;
				mac_b          = q_rd_q;
				state_d        = S_M2;
			end
			S_M2: begin
				mac_ctrl.valid = 1'b1;
				mac_ctrl.dst   = ACC_N2;
				mac_a          = e_rd_q;
				state_d        = elem_last ? S_FLUSH : S_RD;
			end
			S_FLUSH: state_d = S_CSTART;
			S_CSTART: begin
				cos_start = 1'b1;
				state_d   = S_COSW;
			end
			S_COSW: begin
				if (cos_done) begin
					state_d = ent_last ? S_DONE : S_LEN;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Result register contents for the transaction finishing this cycle.
	always_comb begin
		res_load = 1'b0;
		res_next = '{status: ST_CLEARED, best_entry: '0, score: '0,
			entry_count: 7'(cnt_q)};
		if (in_take) begin
			case (op_t'(item.op))
				OP_ADD: begin
					res_load = item.last;
					if (add_bad) begin
						res_next.status = ST_BADLEN;
					end else if (add_full) begin
						res_next.status = ST_FULL;
					end else begin
						res_next.status      = ST_ADDED;
						res_next.entry_count = 7'(cnt_q + CNT_W'(1));
					end
				end
				OP_QUERY: begin
					res_load        = item.last && !query_go;
					res_next.status = ST_EMPTY;
				end
				OP_CLEAR: begin
					res_load             = 1'b1;
					res_next.status      = ST_CLEARED;
					res_next.entry_count = '0;
				end
				default: res_load = 1'b0;
			endcase
		end else if ((state_q == S_DONE) && out_free) begin
			res_load            = 1'b1;
			res_next.status     = ST_FOUND;
			res_next.best_entry = 6'(best_idx_q);
			res_next.score      = (best_q > SCORE_CLIP) ? 16'(SCORE_CLIP) : best_q[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			vlen_q      <= '0;
			cnt_q       <= '0;
			fill_q      <= '0;
			qpos_q      <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				vlen_q <= cfg_wr_data;
			end
			if (in_take) begin
				case (op_t'(item.op))
					OP_ADD: begin
						fill_q <= item.last ? '0 : fill_nx;
						if (add_ok) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					OP_QUERY: qpos_q <= item.last ? '0 : qpos_nx;
					OP_CLEAR: begin
						cnt_q  <= '0;
						fill_q <= '0;
						qpos_q <= '0;
					end
					default: cnt_q <= cnt_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_next;
		end
		if (query_go) begin
			qlen_q     <= qpos_nx;
			ent_q      <= '0;
			best_q     <= SCORE_MIN;
			best_idx_q <= '0;
		end
		if (cand_valid) begin
			ent_q <= ent_q + IDX_W'(1);
			if (cand_score > best_q) begin
				best_q     <= cand_score;
				best_idx_q <= ent_q;
			end
		end
		if (state_q == S_CHK) begin
			elem_q <= '0;
		end else if (state_q == S_M2) begin
			elem_q <= elem_q + DIM_W'(1);
		end
	end

	// Memories: one write port each, registered reads at the scan pointers.
	always_ff @(posedge clk) begin
		if (in_take && (item.op == OP_ADD) && (32'(fill_q) < MAX_DIM)
			&& (32'(cnt_q) < MAX_ENTRIES)) begin
			store_mem[{cnt_q[IDX_W-1:0], fill_q[DIM_W-1:0]}] <= item.element_value;
		end
		e_rd_q <= store_mem[{ent_q, elem_q}];
	end

	always_ff @(posedge clk) begin
		if (add_ok) begin
			len_mem[cnt_q[IDX_W-1:0]] <= fill_nx;
		end
		len_rd_q <= len_mem[ent_q];
	end

	always_ff @(posedge clk) begin
		if (in_take && (item.op == OP_QUERY) && (32'(qpos_q) < MAX_DIM)) begin
			qbuf_mem[qpos_q[DIM_W-1:0]] <= item.element_value;
		end
		q_rd_q <= qbuf_mem[elem_q];
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_cos_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cos_done |-> (state_q == S_COSW))
		else $error("score unit finished outside of its wait state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_ENTRIES)
		else $error("entry count above store size");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(fill_q) <= MAX_DIM + 1) && (32'(qpos_q) <= MAX_DIM + 1))
		else $error("element position above saturation");

	a_mac_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M0) |-> (POS_W'(elem_q) < qlen_q))
		else $error("multiply step past the query length");

endmodule
